[sv/sfcc_pkg.sv]
package sfcc_pkg;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [15:0] WORD_FAIL   = 16'hFFFF;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] HUM_SCALE   = 15'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;

   localparam int RAW_W    = 16;
   localparam int SCALED_W = 15;
   localparam int PROD_W   = 31;

   typedef enum logic {
      CH_TEMP = 1'b0,
      CH_HUM  = 1'b1
   } channel_type;

   // position of the next byte within the six-byte frame
   typedef enum logic [2:0] {
      POS_T_HI  = 3'd0,
      POS_T_LO  = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_HI  = 3'd3,
      POS_H_LO  = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   typedef struct packed {
      channel_type      channel;
      logic             ok;
      logic [RAW_W-1:0] word;
   } word_item_type;

   // CRC-8, MSB first, one byte per call
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[sv/sensor_frame_crc_checker.sv]
// Checks and converts the six-byte measurement frame of a humidity and
// temperature sensor: temperature word, its CRC-8, humidity word, its CRC-8.
// req_*: one frame byte per word; req_tuser marks the first byte of a frame
//   and restarts the position (a partial frame is dropped without a result).
//   After the sixth byte the next byte starts a new frame anyway.
// rsp_*: one word after each CRC byte: channel, raw word (0xFFFF on a CRC
//   mismatch), crc_ok and the value in hundredths (degC or %RH).
// Path: after the CRC byte is accepted, its result passes through the input register,
//   CRC/frame stage, multiply stage and result register before it shows on rsp_tvalid.
// Throughput: one byte per cycle; each stage advances on its own whenever the
//   stage after it is empty or moving, so bytes keep flowing while a result
//   waits in the result register. When the receiver stalls and every stage
//   holds a word, req_tready drops.
// Reset: all stages empty, frame position 0, CRC register 0xFF.
module sensor_frame_crc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] raw_word, [30:16] scaled_value, [31] zero
   output logic [1:0]  rsp_tuser    // [0] word_channel, [1] crc_ok
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // frame state
   sfcc_pkg::pos_type pos_ff, pos_in, pos_cur;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] hi_ff, hi_in;
   logic [7:0] lo_ff, lo_in;

   // word stage
   logic                    w_valid_ff, w_valid_in;
   sfcc_pkg::word_item_type w_item_ff, w_item_in;

   // product stage
   logic                          p_valid_ff, p_valid_in;
   sfcc_pkg::word_item_type       p_item_ff;
   logic [sfcc_pkg::PROD_W-1:0]   p_prod_ff, p_prod_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   sfcc_pkg::word_item_type         rsp_item_ff;
   logic [sfcc_pkg::SCALED_W-1:0]   rsp_scaled_ff, rsp_scaled_in;

   logic out_en, p_en, w_en, in_en, consume, is_crc_pos;

   assign out_en  = !rsp_valid_ff || rsp_tready;
   assign p_en    = !p_valid_ff || out_en;
   assign w_en    = !w_valid_ff || p_en;
   assign in_en   = !in_valid_ff || w_en;
   assign consume = in_valid_ff && w_en;

   assign req_tready = in_en;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_en) begin
         in_valid_in = req_tvalid;
      end
   end

   // frame decode and CRC
   always_comb begin
      pos_cur = pos_ff;
      if (in_start_ff) begin
         pos_cur = sfcc_pkg::POS_T_HI;
      end
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      is_crc_pos = 1'b0;
      w_item_in.channel = sfcc_pkg::CH_TEMP;
      w_item_in.ok      = (in_byte_ff == crc_ff);
      w_item_in.word    = w_item_in.ok ? {hi_ff, lo_ff} : sfcc_pkg::WORD_FAIL;
      case (pos_cur)
         sfcc_pkg::POS_T_HI, sfcc_pkg::POS_H_HI: begin
            hi_in  = in_byte_ff;
            crc_in = sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, in_byte_ff);
            pos_in = (pos_cur == sfcc_pkg::POS_T_HI) ? sfcc_pkg::POS_T_LO
                                                      : sfcc_pkg::POS_H_LO;
         end
         sfcc_pkg::POS_T_LO, sfcc_pkg::POS_H_LO: begin
            lo_in  = in_byte_ff;
            crc_in = sfcc_pkg::crc8_byte(crc_ff, in_byte_ff);
            pos_in = (pos_cur == sfcc_pkg::POS_T_LO) ? sfcc_pkg::POS_T_CRC
                                                      : sfcc_pkg::POS_H_CRC;
         end
         sfcc_pkg::POS_T_CRC: begin
            is_crc_pos = 1'b1;
            crc_in     = sfcc_pkg::CRC_INIT;
            pos_in     = sfcc_pkg::POS_H_HI;
         end
         sfcc_pkg::POS_H_CRC: begin
            is_crc_pos        = 1'b1;
            w_item_in.channel = sfcc_pkg::CH_HUM;
            crc_in            = sfcc_pkg::CRC_INIT;
            pos_in            = sfcc_pkg::POS_T_HI;
         end
         default: begin
            // unused codes behave as the first byte of a frame
            hi_in  = in_byte_ff;
            crc_in = sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, in_byte_ff);
            pos_in = sfcc_pkg::POS_T_LO;
         end
      endcase
      if (!consume) begin
         pos_in = pos_ff;
         crc_in = crc_ff;
         hi_in  = hi_ff;
         lo_in  = lo_ff;
      end
   end

   always_comb begin
      w_valid_in = w_valid_ff;
      if (w_en) begin
         w_valid_in = consume && is_crc_pos;
      end
   end

   // scale product
   always_comb begin
      p_valid_in = p_valid_ff;
      if (p_en) begin
         p_valid_in = w_valid_ff;
      end
      if (w_item_ff.channel == sfcc_pkg::CH_HUM) begin
         p_prod_in = {15'd0, w_item_ff.word} * {16'd0, sfcc_pkg::HUM_SCALE};
      end else begin
         p_prod_in = {15'd0, w_item_ff.word} * {16'd0, sfcc_pkg::TEMP_SCALE};
      end
   end

   // divide by 65535: p = q0*65535 + (q0 + low half); one correction step
   logic [14:0] div_q0;
   logic [16:0] div_rem;
   logic [15:0] div_q;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_en) begin
         rsp_valid_in = p_valid_ff;
      end
      div_q0  = p_prod_ff[30:16];
      div_rem = {1'b0, p_prod_ff[15:0]} + {2'b00, div_q0};
      div_q   = {1'b0, div_q0} + {15'd0, (div_rem >= sfcc_pkg::FULL_SCALE)};
      if (p_item_ff.channel == sfcc_pkg::CH_HUM) begin
         rsp_scaled_in = div_q[14:0];
      end else begin
         rsp_scaled_in = 15'(div_q - sfcc_pkg::TEMP_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         w_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= sfcc_pkg::POS_T_HI;
         crc_ff       <= sfcc_pkg::CRC_INIT;
         hi_ff        <= 8'd0;
         lo_ff        <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         w_valid_ff   <= w_valid_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (w_en) begin
         w_item_ff <= w_item_in;
      end
      if (p_en) begin
         p_item_ff <= w_item_ff;
         p_prod_ff <= p_prod_in;
      end
      if (out_en) begin
         rsp_item_ff   <= p_item_ff;
         rsp_scaled_ff <= rsp_scaled_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_scaled_ff, rsp_item_ff.word};
   assign rsp_tuser  = {rsp_item_ff.ok, rsp_item_ff.channel};

   // a failed check always reports the all-ones word
   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.ok |-> rsp_item_ff.word == sfcc_pkg::WORD_FAIL)
      else $error("failed CRC word not forced to all ones");

   // humidity never goes negative nor above 100.00 %
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.channel == sfcc_pkg::CH_HUM
      |-> !rsp_scaled_ff[14] && rsp_scaled_ff <= 15'd10000)
      else $error("humidity value out of range");

   // a consumed CRC byte leaves a word in the word stage
   a_crc_word: assert property (@(posedge clock) disable iff (reset)
      consume && is_crc_pos |=> w_valid_ff)
      else $error("CRC byte produced no word");

   // the running CRC restarts after each check
   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      consume && is_crc_pos |=> crc_ff == sfcc_pkg::CRC_INIT)
      else $error("running CRC not restarted after check");

   // a word only enters the word stage when a CRC byte is consumed
   a_word_src: assert property (@(posedge clock) disable iff (reset)
      w_en && !(consume && is_crc_pos) |=> !w_valid_ff)
      else $error("word stage loaded without a CRC byte");

endmodule

[sim/tb.sv]
module tb;

   typedef struct {
      sfcc_pkg::channel_type channel;
      logic                  ok;
      logic [15:0]           raw;
      logic [14:0]           scaled;
   } word_result_type;

   class crc_frame_tracker;
      logic [2:0]      next_pos;
      logic [7:0]      crc_acc;
      logic [7:0]      hi_hold;
      logic [7:0]      lo_hold;
      word_result_type pending_words[$];
      int              failures;

      function new();
         next_pos = sfcc_pkg::POS_T_HI;
         crc_acc  = sfcc_pkg::CRC_INIT;
         hi_hold  = 8'h00;
         lo_hold  = 8'h00;
         failures = 0;
      endfunction

      static function logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
         logic [7:0] v;
         v = c ^ b;
         for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ sfcc_pkg::CRC_POLY) : {v[6:0], 1'b0};
         end
         return v;
      endfunction

      function void close_word(sfcc_pkg::channel_type ch, logic [7:0] rx_crc);
         word_result_type w;
         logic [31:0]     prod;
         w.channel = ch;
         w.ok      = (rx_crc == crc_acc);
         w.raw     = w.ok ? {hi_hold, lo_hold} : sfcc_pkg::WORD_FAIL;
         if (ch == sfcc_pkg::CH_TEMP) begin
            prod = 32'd17500 * w.raw;
            prod = prod / 32'd65535 - 32'd4500;
         end else begin
            prod = 32'd10000 * w.raw;
            prod = prod / 32'd65535;
         end
         w.scaled = prod[14:0];
         pending_words.push_back(w);
         crc_acc = sfcc_pkg::CRC_INIT;
      endfunction

      // one accepted frame byte
      function void take_byte(logic [7:0] b, logic start);
         logic [2:0] p;
         p = start ? sfcc_pkg::POS_T_HI : next_pos;
         if (p > sfcc_pkg::POS_H_CRC) p = sfcc_pkg::POS_T_HI;
         case (p)
            sfcc_pkg::POS_T_HI, sfcc_pkg::POS_H_HI: begin
               hi_hold = b;
               crc_acc = crc8_step(sfcc_pkg::CRC_INIT, b);
            end
            sfcc_pkg::POS_T_LO, sfcc_pkg::POS_H_LO: begin
               lo_hold = b;
               crc_acc = crc8_step(crc_acc, b);
            end
            sfcc_pkg::POS_T_CRC: close_word(sfcc_pkg::CH_TEMP, b);
            default:             close_word(sfcc_pkg::CH_HUM, b);
         endcase
         next_pos = (p == sfcc_pkg::POS_H_CRC) ? sfcc_pkg::POS_T_HI : p + 3'd1;
      endfunction

      function void compare_word(logic [31:0] data, logic [1:0] user);
         word_result_type w;
         if (pending_words.size() == 0) begin
            $error("unexpected result word: tdata=%h tuser=%b", data, user);
            failures++;
            return;
         end
         w = pending_words.pop_front();
         if (user[0] !== w.channel) begin
            $error("word_channel: expected %0d, got %0d", w.channel, user[0]);
            failures++;
         end
         if (user[1] !== w.ok) begin
            $error("crc_ok: expected %0d, got %0d", w.ok, user[1]);
            failures++;
         end
         if (data[15:0] !== w.raw) begin
            $error("raw_word: expected %h, got %h", w.raw, data[15:0]);
            failures++;
         end
         if (data[30:16] !== w.scaled) begin
            $error("scaled_value: expected %0d, got %0d",
                   $signed(w.scaled), $signed(data[30:16]));
            failures++;
         end
         if (data[31] !== 1'b0) begin
            $error("tdata pad bit: expected 0, got %b", data[31]);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [15:0] raw_word, [30:16] scaled_value, [31] zero
   logic [1:0]  rsp_tuser;           // [0] word_channel, [1] crc_ok

   crc_frame_tracker tracker = new();
   bit quiet = 1'b0;
   int bytes_sent = 0;

   sensor_frame_crc_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.compare_word(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata, req_tuser);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet || ($urandom_range(0, 99) >= 37);
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      while (!quiet && $urandom_range(0, 99) < 37) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input bit bad_t, input bit bad_h, input logic start);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = crc_frame_tracker::crc8_step(
                 crc_frame_tracker::crc8_step(sfcc_pkg::CRC_INIT, t_word[15:8]),
                 t_word[7:0]);
      h_crc = crc_frame_tracker::crc8_step(
                 crc_frame_tracker::crc8_step(sfcc_pkg::CRC_INIT, h_word[15:8]),
                 h_word[7:0]);
      if (bad_t) t_crc ^= 8'($urandom_range(1, 255));
      if (bad_h) h_crc ^= 8'($urandom_range(1, 255));
      send_byte(t_word[15:8], start);
      send_byte(t_word[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h_word[15:8], 1'b0);
      send_byte(h_word[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
   endtask

   initial begin
      int  sel;
      int  n;
      logic start;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // extremes, good and bad CRC, wrap without frame_start, abandoned frame
      send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
      send_frame(16'h5AA5, 16'hA55A, 1'b1, 1'b1, 1'b1);
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);

      while (bytes_sent < 1230) begin
         quiet = (bytes_sent >= 500 && bytes_sent < 700);
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            start = (tracker.next_pos == sfcc_pkg::POS_T_HI) ?
                    1'($urandom_range(0, 1)) : 1'b1;
            send_frame(16'($urandom), 16'($urandom), $urandom_range(0, 99) < 20,
                       $urandom_range(0, 99) < 20, start);
         end else if (sel < 87) begin
            // frame cut short, then dropped by the next frame_start
            n = $urandom_range(1, 5);
            send_byte(8'($urandom), 1'b1);
            for (int i = 1; i < n; i++) send_byte(8'($urandom), 1'b0);
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom), $urandom_range(0, 9) == 0);
         end
      end
      quiet = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #1600000;
      $display("Verification failed");
      $finish;
   end

endmodule
